>>> rtl/uemr_pkg.sv
// ----------------------------------------------------------------------------
// uemr_pkg
// Shared types, widths and reset values for the echo median ranger.
// ----------------------------------------------------------------------------
package uemr_pkg;

    localparam int ECHO_W   = 16;
    localparam int SCALE_W  = 16;
    localparam int DIST_W   = 19;
    localparam int PROD_W   = ECHO_W + SCALE_W;
    localparam int FRAC_SH  = 13;
    localparam int CFG_W    = 19;
    localparam int CFG_IDX_W = 2;

    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST  = 16'd22479;
    localparam logic [ECHO_W-1:0]  TIMEOUT_US_RST   = 16'd30000;
    localparam logic [DIST_W-1:0]  EMPTY_MARGIN_RST = 19'd800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_SCALE  = 2'd0,
        CFG_TIMEOUT_US   = 2'd1,
        CFG_EMPTY_MARGIN = 2'd2
    } cfg_idx_t;

    // Position of a sample inside its burst of three
    typedef enum logic [2:0] {
        POS_FIRST  = 3'b001,
        POS_SECOND = 3'b010,
        POS_THIRD  = 3'b100
    } pos_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] value;
    } sample_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              distance_valid;
        logic              empty_res;
        logic              calibrated;
    } res_t;

    // Ordering key: a failed sample ranks below every valid distance
    function automatic logic [DIST_W:0] rank(input sample_t s);
        logic [DIST_W:0] k;
        k = s.valid ? ({1'b0, s.value} + {{DIST_W{1'b0}}, 1'b1}) : '0;
        return k;
    endfunction

endpackage

>>> rtl/ultrasonic_echo_median_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_median_ranger
// Echo ranger: echo time to distance, median of three per burst, empty flag.
// ----------------------------------------------------------------------------
// Throughput: one echo sample per cycle while in_stall is low; one result
//   per three samples.
// Path: input register, multiplier register, then median into result reg.
// Reset: burst restarts at its first sample, held samples and reference are
//   marked failed/invalid, configuration returns to its default values.
module ultrasonic_echo_median_ranger
    import uemr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [ECHO_W-1:0]    echo_us,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DIST_W-1:0]    distance,
    output logic                 distance_valid,
    output logic                 empty_res,
    output logic                 calibrated
);

    logic [SCALE_W-1:0] speed_scale_reg;
    logic [ECHO_W-1:0]  timeout_us_reg;
    logic [DIST_W-1:0]  empty_margin_reg;

    pos_t               pos_reg;
    pos_t               pos_next;

    logic               s1_v_reg;
    logic               s1_cmd_reg;
    logic [ECHO_W-1:0]  s1_echo_reg;
    pos_t               s1_pos_reg;

    logic               s2_v_reg;
    logic               s2_cmd_reg;
    pos_t               s2_pos_reg;
    sample_t            s2_smp_reg;

    logic               out_v_reg;
    res_t               out_reg;

    sample_t            conv_smp;
    res_t               burst_res;

    logic               in_go;
    logic               out_free;
    logic               s2_last;
    logic               s2_go;
    logic               s2_free;
    logic               s1_go;
    logic               s1_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_scale_reg  <= SPEED_SCALE_RST;
            timeout_us_reg   <= TIMEOUT_US_RST;
            empty_margin_reg <= EMPTY_MARGIN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SPEED_SCALE:  speed_scale_reg  <= cfg_data[SCALE_W-1:0];
                CFG_TIMEOUT_US:   timeout_us_reg   <= cfg_data[ECHO_W-1:0];
                CFG_EMPTY_MARGIN: empty_margin_reg <= cfg_data[DIST_W-1:0];
                default:          ;
            endcase
        end
    end

    // Pipeline flow: a non-result sample always leaves stage 2,
    // a result waits for the result register
    assign s2_last  = (s2_pos_reg == POS_THIRD);
    assign out_free = !out_v_reg || !out_stall;
    assign s2_go    = s2_v_reg && (!s2_last || out_free);
    assign s2_free  = !s2_v_reg || s2_go;
    assign s1_go    = s1_v_reg && s2_free;
    assign s1_free  = !s1_v_reg || s1_go;
    assign in_stall = !s1_free;
    assign in_go    = in_valid && s1_free;

    always_comb
    begin
        unique case (pos_reg)
            POS_FIRST:  pos_next = POS_SECOND;
            POS_SECOND: pos_next = POS_THIRD;
            default:    pos_next = POS_FIRST;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= POS_FIRST;
        else if (in_go)
            pos_reg <= pos_next;
    end

    // Stage 1: input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (s1_free)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_go)
        begin
            s1_cmd_reg  <= cmd;
            s1_echo_reg <= echo_us;
            s1_pos_reg  <= pos_reg;
        end
    end

    uemr_conv u_conv (
        .echo        (s1_echo_reg),
        .speed_scale (speed_scale_reg),
        .timeout_us  (timeout_us_reg),
        .smp         (conv_smp)
    );

    // Stage 2: converted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg   <= 1'b0;
            s2_pos_reg <= POS_FIRST;
        end
        else if (s2_free)
        begin
            s2_v_reg <= s1_v_reg;
            if (s1_go)
                s2_pos_reg <= s1_pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            s2_smp_reg <= conv_smp;
        end
    end

    uemr_burst u_burst (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (s2_go),
        .pos          (s2_pos_reg),
        .cmd          (s2_cmd_reg),
        .smp          (s2_smp_reg),
        .empty_margin (empty_margin_reg),
        .res          (burst_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (s2_go && s2_last)
            out_v_reg <= 1'b1;
        else if (!out_stall)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_go && s2_last)
            out_reg <= burst_res;
    end

    assign out_valid      = out_v_reg;
    assign distance       = out_reg.distance;
    assign distance_valid = out_reg.distance_valid;
    assign empty_res      = out_reg.empty_res;
    assign calibrated     = out_reg.calibrated;

    // A finished burst waiting on a busy result register holds its sample
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && s2_last && out_v_reg && out_stall)
        |=> (s2_v_reg && s2_last && $stable(s2_smp_reg)))
        else $error("pending burst result dropped");

    // Input is only held off while stage 1 is occupied
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_v_reg)
        else $error("input stalled with empty input register");

    // A failed median reports zero distance and never empty
    a_invalid_res: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_reg.distance_valid)
        |-> ((out_reg.distance == '0) && !out_reg.empty_res))
        else $error("invalid result carries distance or empty flag");

    // Once calibrated, later results stay calibrated
    a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_reg.calibrated && s2_go && s2_last)
        |=> out_reg.calibrated)
        else $error("calibration lost");

endmodule

>>> rtl/uemr_conv.sv
// ----------------------------------------------------------------------------
// uemr_conv
// Turns an echo time into a distance in 1/16 mm and flags failed samples.
// ----------------------------------------------------------------------------
module uemr_conv
    import uemr_pkg::*;
(
    input  logic [ECHO_W-1:0]  echo,
    input  logic [SCALE_W-1:0] speed_scale,
    input  logic [ECHO_W-1:0]  timeout_us,
    output sample_t            smp
);

    logic [PROD_W-1:0] prod;
    logic              ok;

    assign prod = PROD_W'(echo) * PROD_W'(speed_scale);
    assign ok   = (echo != '0) && (echo <= timeout_us);

    always_comb
    begin
        smp.valid = ok;
        smp.value = ok ? prod[FRAC_SH +: DIST_W] : '0;
    end

endmodule

>>> rtl/uemr_burst.sv
// ----------------------------------------------------------------------------
// uemr_burst
// Holds the first two samples of a burst and the calibration reference;
// on the third sample fills in failed samples, takes the median and
// evaluates the empty flag.
// ----------------------------------------------------------------------------
module uemr_burst
    import uemr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  pos_t              pos,
    input  logic              cmd,
    input  sample_t           smp,
    input  logic [DIST_W-1:0] empty_margin,
    output res_t              res
);

    sample_t first_reg;
    sample_t second_reg;
    sample_t ref_reg;
    sample_t ref_next;
    sample_t m1;
    sample_t m2;
    sample_t m3;
    sample_t med;
    logic [DIST_W:0] ka;
    logic [DIST_W:0] kb;
    logic [DIST_W:0] kc;
    logic [DIST_W:0] limit;
    logic            third;

    assign third = !(pos == POS_FIRST || pos == POS_SECOND);

    always_comb
    begin
        m1 = first_reg;
        m2 = second_reg;
        m3 = smp;
        if (!m1.valid && m2.valid)
            m1 = m2;
        if (!m3.valid && m2.valid)
            m3 = m2;
        if (!m2.valid && m1.valid)
            m2 = m1;
    end

    assign ka = rank(m1);
    assign kb = rank(m2);
    assign kc = rank(m3);

    always_comb
    begin
        if ((ka >= kb && ka <= kc) || (ka <= kb && ka >= kc))
            med = m1;
        else if ((kb >= ka && kb <= kc) || (kb <= ka && kb >= kc))
            med = m2;
        else
            med = m3;
        if (!med.valid)
            med.value = '0;
    end

    // Calibration takes only a valid, nonzero median
    always_comb
    begin
        ref_next = ref_reg;
        if (cmd && med.valid && (med.value != '0))
            ref_next = med;
    end

    assign limit = {1'b0, ref_next.value} + {1'b0, empty_margin};

    always_comb
    begin
        res.distance       = med.value;
        res.distance_valid = med.valid;
        res.empty_res      = ref_next.valid && med.valid && ({1'b0, med.value} > limit);
        res.calibrated     = ref_next.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
            ref_reg    <= '0;
        end
        else if (go)
        begin
            unique case (pos)
                POS_FIRST:  first_reg  <= smp;
                POS_SECOND: second_reg <= smp;
                default:    ;
            endcase
            if (third)
                ref_reg <= ref_next;
        end
    end

    // Reference never loses validity once held
    a_ref_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ref_reg.valid |=> ref_reg.valid)
        else $error("reference lost validity");

    // A newly taken reference is a valid, nonzero distance
    a_ref_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ref_reg.valid |-> (ref_reg.value != '0))
        else $error("reference holds zero distance");

    // Empty needs a valid median and a held reference
    a_empty_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (go && third && res.empty_res) |-> (res.calibrated && res.distance_valid))
        else $error("empty flag without valid median and reference");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the echo median ranger. A directed table covers
// failed samples, neighbour replacement, failed medians, calibration and the
// register extremes. Random bursts then run under several register settings.
// Each result transfer is compared with a local predictor or a table entry.
// ----------------------------------------------------------------------------
module tb_top;
    import uemr_pkg::*;

    localparam logic CMD_NORMAL    = 1'b0;
    localparam logic CMD_CALIBRATE = 1'b1;
    localparam int   SETTLE_CYCLES = 6;
    localparam int   NUM_PHASES    = 8;

    typedef enum logic {ROW_ECHO, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic              cmd_v;
        logic [ECHO_W-1:0] echo_v;
        bit                typed;
        res_t              want;
        cfg_idx_t          idx;
        logic [CFG_W-1:0]  data;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 cmd = 1'b0;
    logic [ECHO_W-1:0]    echo_us = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [DIST_W-1:0]    distance;
    logic                 distance_valid;
    logic                 empty_res;
    logic                 calibrated;

    // predictor state and register copies
    pos_t                 burst_pos;
    sample_t              held_first;
    sample_t              held_second;
    sample_t              last_range;
    sample_t              ref_range;
    logic [SCALE_W-1:0]   scale_r;
    logic [ECHO_W-1:0]    tmo_r;
    logic [DIST_W-1:0]    margin_r;

    res_t                 pending_ranges[$];
    dir_row_t             dir_rows[$];
    bit                   quiet = 1'b0;
    int                   errors = 0;
    int                   echoes_sent = 0;
    int                   ranges_checked = 0;
    int                   valid_seen = 0;
    int                   empty_seen = 0;
    int                   cfg_writes = 0;

    ultrasonic_echo_median_ranger uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .echo_us        (echo_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .distance       (distance),
        .distance_valid (distance_valid),
        .empty_res      (empty_res),
        .calibrated     (calibrated)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("%0t watchdog expired with %0d results outstanding", $time,
                 pending_ranges.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic sample_t echo_to_range(input logic [ECHO_W-1:0] e);
        sample_t      s;
        logic [31:0]  prod;
        prod = {16'd0, e} * {16'd0, scale_r};
        if (e == '0 || e > tmo_r)
        begin
            s.valid = 1'b0;
            s.value = '0;
        end
        else
        begin
            s.valid = 1'b1;
            s.value = prod[31:13];
        end
        return s;
    endfunction

    // failed samples sort below every valid distance
    function automatic logic [DIST_W:0] order_key(input sample_t s);
        return s.valid ? ({1'b0, s.value} + {{DIST_W{1'b0}}, 1'b1}) : '0;
    endfunction

    function automatic sample_t median_range(input sample_t a, input sample_t b,
                                             input sample_t c);
        logic [DIST_W:0] ka;
        logic [DIST_W:0] kb;
        logic [DIST_W:0] kc;
        ka = order_key(a);
        kb = order_key(b);
        kc = order_key(c);
        if ((ka >= kb && ka <= kc) || (ka <= kb && ka >= kc))
            return a;
        if ((kb >= ka && kb <= kc) || (kb <= ka && kb >= kc))
            return b;
        return c;
    endfunction

    task automatic range_predict(input logic c_in, input logic [ECHO_W-1:0] e_in,
                                 output bit produced, output res_t r);
        sample_t cur;
        sample_t m1;
        sample_t m2;
        sample_t m3;
        sample_t med;
        cur = echo_to_range(e_in);
        produced = 1'b0;
        r = '0;
        if (burst_pos == POS_FIRST)
        begin
            held_first = cur;
            burst_pos = POS_SECOND;
        end
        else if (burst_pos == POS_SECOND)
        begin
            held_second = cur;
            burst_pos = POS_THIRD;
        end
        else
        begin
            burst_pos = POS_FIRST;
            m1 = held_first;
            m2 = held_second;
            m3 = cur;
            // neighbour replacement, in this order
            if (!m1.valid && m2.valid)
                m1 = m2;
            if (!m3.valid && m2.valid)
                m3 = m2;
            if (!m2.valid && m1.valid)
                m2 = m1;
            med = median_range(m1, m2, m3);
            if (!med.valid)
                med.value = '0;
            last_range = med;
            if (c_in == CMD_CALIBRATE && med.valid && med.value != '0)
                ref_range = med;
            produced = 1'b1;
            r.distance = med.value;
            r.distance_valid = med.valid;
            r.empty_res = ref_range.valid && last_range.valid &&
                          ({1'b0, last_range.value} >
                           ({1'b0, ref_range.value} + {1'b0, margin_r}));
            r.calibrated = ref_range.valid;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic res_t res_of(input logic [DIST_W-1:0] d, input logic v,
                                    input logic e, input logic c);
        res_t r;
        r.distance = d;
        r.distance_valid = v;
        r.empty_res = e;
        r.calibrated = c;
        return r;
    endfunction

    task automatic add_echo(input logic c_in, input logic [ECHO_W-1:0] e_in,
                            input bit typed, input res_t want);
        dir_row_t row;
        row.kind = ROW_ECHO;
        row.cmd_v = c_in;
        row.echo_v = e_in;
        row.typed = typed;
        row.want = want;
        row.idx = CFG_SPEED_SCALE;
        row.data = '0;
        dir_rows.push_back(row);
    endtask

    task automatic add_cfg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
        dir_row_t row;
        row.kind = ROW_CFG;
        row.cmd_v = CMD_NORMAL;
        row.echo_v = '0;
        row.typed = 1'b0;
        row.want = '0;
        row.idx = idx;
        row.data = data;
        dir_rows.push_back(row);
    endtask

    task automatic send_echo(input logic c_in, input logic [ECHO_W-1:0] e_in,
                             input bit typed, input res_t want);
        int   gap;
        bit   produced;
        res_t r;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c_in;
        echo_us <= e_in;
        do
            @(posedge clk);
        while (in_stall);
        range_predict(c_in, e_in, produced, r);
        if (produced)
            pending_ranges.push_back(typed ? want : r);
        echoes_sent++;
    endtask

    // drop valid, wait for every result, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_SPEED_SCALE:  scale_r = data[SCALE_W-1:0];
            CFG_TIMEOUT_US:   tmo_r = data[ECHO_W-1:0];
            CFG_EMPTY_MARGIN: margin_r = data[DIST_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    function automatic logic [ECHO_W-1:0] pick_echo();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return (tmo_r == 16'hFFFF) ? 16'hFFFF :
                      ECHO_W'($urandom_range(int'(tmo_r) + 1, 65535));
            2: return ECHO_W'($urandom);
            default: return ECHO_W'($urandom_range(1, int'(tmo_r)));
        endcase
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, then compare each transfer
    // ------------------------------------------------------------------
    initial
    begin : result_stall
        int n;
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 14);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_ranges.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual distance %0d",
                         $time, distance);
                errors++;
            end
            else
            begin
                w = pending_ranges.pop_front();
                check_field("distance", 32'(w.distance), 32'(distance));
                check_field("distance_valid", 32'(w.distance_valid), 32'(distance_valid));
                check_field("empty_res", 32'(w.empty_res), 32'(empty_res));
                check_field("calibrated", 32'(w.calibrated), 32'(calibrated));
                ranges_checked++;
                if (w.distance_valid)
                    valid_seen++;
                if (w.empty_res)
                    empty_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int   count;
        logic c_rand;
        burst_pos = POS_FIRST;
        held_first = '0;
        held_second = '0;
        last_range = '0;
        ref_range = '0;
        scale_r = SPEED_SCALE_RST;
        tmo_r = TIMEOUT_US_RST;
        margin_r = EMPTY_MARGIN_RST;

        // all failed right after reset, calibration request ignored
        add_echo(CMD_NORMAL, 16'd0, 1'b0, '0);
        add_echo(CMD_CALIBRATE, 16'd0, 1'b0, '0);
        add_echo(CMD_CALIBRATE, 16'd0, 1'b1, res_of('0, 1'b0, 1'b0, 1'b0));
        // beyond timeout on the first two samples, zero echo on the third
        add_echo(CMD_CALIBRATE, 16'hFFFF, 1'b0, '0);
        add_echo(CMD_NORMAL, 16'd30001, 1'b0, '0);
        add_echo(CMD_NORMAL, 16'd0, 1'b1, res_of('0, 1'b0, 1'b0, 1'b0));
        // smallest and timeout-edge echoes, take the reference
        add_echo(CMD_NORMAL, 16'd1, 1'b0, '0);
        add_echo(CMD_NORMAL, 16'd30000, 1'b0, '0);
        add_echo(CMD_CALIBRATE, 16'd1000, 1'b0, '0);
        // outer samples replaced from the middle one
        add_echo(CMD_NORMAL, 16'd0, 1'b0, '0);
        add_echo(CMD_NORMAL, 16'd5000, 1'b0, '0);
        add_echo(CMD_NORMAL, 16'd0, 1'b0, '0);
        // middle replaced from the first
        add_echo(CMD_NORMAL, 16'd4000, 1'b0, '0);
        add_echo(CMD_NORMAL, 16'd0, 1'b0, '0);
        add_echo(CMD_NORMAL, 16'hFFFF, 1'b0, '0);
        // two failed samples give a failed median, reference kept
        add_echo(CMD_NORMAL, 16'd0, 1'b0, '0);
        add_echo(CMD_NORMAL, 16'd0, 1'b0, '0);
        add_echo(CMD_NORMAL, 16'd2000, 1'b1, res_of('0, 1'b0, 1'b0, 1'b1));
        // zero scale: valid zero distance must not calibrate
        add_cfg(CFG_SPEED_SCALE, 19'd0);
        add_echo(CMD_CALIBRATE, 16'd100, 1'b0, '0);
        add_echo(CMD_CALIBRATE, 16'd200, 1'b0, '0);
        add_echo(CMD_CALIBRATE, 16'd300, 1'b1, res_of('0, 1'b1, 1'b0, 1'b1));
        // full scale, widest timeout, zero margin
        add_cfg(CFG_SPEED_SCALE, 19'd65535);
        add_cfg(CFG_TIMEOUT_US, 19'd65535);
        add_cfg(CFG_EMPTY_MARGIN, 19'd0);
        add_echo(CMD_NORMAL, 16'hFFFF, 1'b0, '0);
        add_echo(CMD_CALIBRATE, 16'hFFFF, 1'b0, '0);
        add_echo(CMD_NORMAL, 16'hFFFF, 1'b0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            else
                send_echo(dir_rows[i].cmd_v, dir_rows[i].echo_v,
                          dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            quiet = 1'b0;
            if (p == 0)
            begin
                write_reg(CFG_SPEED_SCALE, CFG_W'(SPEED_SCALE_RST));
                write_reg(CFG_TIMEOUT_US, CFG_W'(TIMEOUT_US_RST));
                write_reg(CFG_EMPTY_MARGIN, CFG_W'(EMPTY_MARGIN_RST));
            end
            else
            begin
                write_reg(CFG_SPEED_SCALE, (p == 2) ? 19'd0 :
                          (p == 3) ? 19'd65535 : CFG_W'($urandom_range(0, 65535)));
                write_reg(CFG_TIMEOUT_US, (p == 4) ? 19'd1 :
                          (p == 3) ? 19'd65535 : CFG_W'($urandom_range(1, 65535)));
                write_reg(CFG_EMPTY_MARGIN, (p == 5) ? 19'd0 :
                          (p == 6) ? 19'd524287 : CFG_W'($urandom_range(0, 20000)));
            end
            quiet = (p % 3 == 2);
            // one phase ends mid-burst so later writes land inside a burst
            count = (p == 3) ? 191 : 192;
            for (int k = 0; k < count; k++)
            begin
                c_rand = ($urandom_range(0, 5) == 0) ? CMD_CALIBRATE : CMD_NORMAL;
                send_echo(c_rand, pick_echo(), 1'b0, '0);
            end
        end

        quiet = 1'b0;
        settle();
        $display("Sent %0d echo samples over %0d register writes", echoes_sent, cfg_writes);
        $display("Checked %0d ranging results: %0d valid, %0d flagged empty",
                 ranges_checked, valid_seen, empty_seen);
        if (errors == 0 && pending_ranges.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/uemr_pkg.sv
rtl/uemr_conv.sv
rtl/uemr_burst.sv
rtl/ultrasonic_echo_median_ranger.sv
dv/tb_top.sv
